// ----- hw/rtl/cst_pkg.sv -----
// package for the counting semaphore table: operation and status codes,
// field widths and the request / response payload types
// no dependencies
package cst_pkg;

	localparam int OP_W = 3;
	localparam int IDX_W = 8;
	localparam int VALUE_W = 16;
	localparam int REF_W = 8;
	localparam int STATUS_W = 2;
	localparam int SEM_COUNT_DEF = 16;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_OPEN = 3'd1;
	localparam logic [OP_W-1:0] OP_OPEN_OR_CREATE = 3'd2;
	localparam logic [OP_W-1:0] OP_CLOSE = 3'd3;
	localparam logic [OP_W-1:0] OP_UP = 3'd4;
	localparam logic [OP_W-1:0] OP_DOWN = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BLOCK = 2'd2;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;
	localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [IDX_W-1:0]   sem_index;
		logic [VALUE_W-1:0] init_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [REF_W-1:0]    open_count;
	} rsp_t;

	// one table entry as stored in the ram
	typedef struct packed {
		logic [REF_W-1:0]   ref_count;
		logic [VALUE_W-1:0] sem_value;
	} entry_t;

endpackage

// ----- hw/rtl/cst_ram.sv -----
// generic single-write, single-read ram with a registered read port
// no dependencies
module cst_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/counting_semaphore_table_core.sv -----
// top level of the counting semaphore table: request decode, read-modify-write
// of the entry ram and the response register
// depends on cst_pkg and cst_ram
//
// A bank of SEM_COUNT counting semaphores, each holding a 16-bit value and an
// 8-bit open reference count, all zero after reset. Every request (create,
// open, open-or-create, close, up, down) returns one response with a status
// and, for close, the reference count that remains. A down on a zero value
// never waits: it answers would-block and the requester retries. An accepted
// request reads its entry from the ram into stage 1, where the entry is updated
// and written back as the response register is loaded. A new request can be
// accepted in every cycle unless stage 1 is stalled; a write to the entry that
// the next request reads is forwarded, so back-to-back requests to the same
// entry see each other's updates. Reset takes effect at once through per-entry
// valid flops, with no clearing pass; the only stall comes from a response that
// is not taken.
module counting_semaphore_table_core #(
	parameter int SEM_COUNT = cst_pkg::SEM_COUNT_DEF,
	localparam int AW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cst_pkg::rsp_t rsp
);

	localparam int DATA_W = cst_pkg::REF_W + cst_pkg::VALUE_W;

	logic                      req_acc;
	logic                      s1_adv;
	logic                      s1_valid;
	cst_pkg::req_t             req_s1;
	logic                      in_range_s1;
	logic                      vld_s1;
	logic                      fwd_s1;
	cst_pkg::entry_t           fwd_data_s1;
	logic [SEM_COUNT-1:0]      valid_q;
	logic                      out_valid_q;
	cst_pkg::rsp_t             out_data_q;
	logic [DATA_W-1:0]         rdata;
	cst_pkg::entry_t           cur;
	cst_pkg::entry_t           nxt;
	logic                      upd;
	logic                      wr_en;
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;
	logic                      in_range;
	cst_pkg::rsp_t             rsp_nxt;

	// handshake: stage 1 moves on when the response register is free or taken
	assign s1_adv = !out_valid_q || rsp_ready;
	assign req_ready = !s1_valid || s1_adv;
	assign req_acc = req_valid && req_ready;
	assign in_range = {1'b0, req.sem_index} < (cst_pkg::IDX_W + 1)'(SEM_COUNT);
	assign raddr = req.sem_index[AW-1:0];
	assign waddr = req_s1.sem_index[AW-1:0];
	assign wr_en = s1_valid && s1_adv && upd;

	cst_ram #(
		.WIDTH(DATA_W),
		.DEPTH(SEM_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (nxt),
		.re    (req_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_ready) begin
			s1_valid <= req_valid;
		end
	end

	// stage 1 payload, entry valid flag and forwarding of a same-entry write
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
			in_range_s1 <= in_range;
			vld_s1 <= valid_q[raddr];
			fwd_s1 <= wr_en && (waddr == raddr);
			fwd_data_s1 <= nxt;
		end
	end

	// per-entry valid flags: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// current entry contents
	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (vld_s1) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	// operation decode and entry update
	always_comb begin
		nxt = cur;
		upd = 1'b0;
		rsp_nxt.status = cst_pkg::ST_ERR;
		rsp_nxt.open_count = '0;
		if (in_range_s1) begin
			case (req_s1.operation)
				cst_pkg::OP_CREATE: begin
					if (cur.ref_count == '0) begin
						nxt.sem_value = req_s1.init_value;
						nxt.ref_count = cst_pkg::REF_W'(1);
						upd = 1'b1;
						rsp_nxt.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_OPEN: begin
					if (cur.ref_count != '0 && cur.ref_count != cst_pkg::REF_MAX) begin
						nxt.ref_count = cur.ref_count + cst_pkg::REF_W'(1);
						upd = 1'b1;
						rsp_nxt.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_OPEN_OR_CREATE: begin
					if (cur.ref_count == '0) begin
						nxt.sem_value = req_s1.init_value;
						nxt.ref_count = cst_pkg::REF_W'(1);
						upd = 1'b1;
						rsp_nxt.status = cst_pkg::ST_OK;
					end else if (cur.ref_count != cst_pkg::REF_MAX) begin
						nxt.ref_count = cur.ref_count + cst_pkg::REF_W'(1);
						upd = 1'b1;
						rsp_nxt.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_CLOSE: begin
					rsp_nxt.status = cst_pkg::ST_OK;
					if (cur.ref_count != '0) begin
						nxt.ref_count = cur.ref_count - cst_pkg::REF_W'(1);
						upd = 1'b1;
						rsp_nxt.open_count = cur.ref_count - cst_pkg::REF_W'(1);
					end
				end
				cst_pkg::OP_UP: begin
					if (cur.ref_count != '0 && cur.sem_value != cst_pkg::VALUE_MAX) begin
						nxt.sem_value = cur.sem_value + cst_pkg::VALUE_W'(1);
						upd = 1'b1;
						rsp_nxt.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_DOWN: begin
					if (cur.ref_count != '0) begin
						if (cur.sem_value == '0) begin
							rsp_nxt.status = cst_pkg::ST_BLOCK;
						end else begin
							nxt.sem_value = cur.sem_value - cst_pkg::VALUE_W'(1);
							upd = 1'b1;
							rsp_nxt.status = cst_pkg::ST_OK;
						end
					end
				end
				default: begin
					upd = 1'b0;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			out_data_q <= rsp_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_data_q;

	// out-of-range requests never touch the table
	a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !in_range_s1) |-> !wr_en)
		else $error("write for an out-of-range request");

	// a stalled request keeps its entry and operation
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> (s1_valid && $stable(req_s1)))
		else $error("stage 1 request changed while stalled");

	// a written entry is marked valid afterwards
	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(waddr)])
		else $error("entry not marked valid after write");

	// only a successful close reports a nonzero reference count
	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status != cst_pkg::ST_OK) |-> (out_data_q.open_count == '0))
		else $error("nonzero open count on a failed request");

endmodule

// ----- tb/sv/tb.sv -----
// testbench for counting_semaphore_table_core: directed table then random episodes,
// every response checked in order against the table's value or a model of the semaphore bank
// depends on cst_pkg and the core rtl
`timescale 1ns / 1ps

module tb;

	localparam int SEM_COUNT = cst_pkg::SEM_COUNT_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_TARGET = 1100;
	localparam int PAUSE_AT = 700;
	localparam int FILL_INDEX = 9;

	// operation codes the block does not define
	localparam logic [cst_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [cst_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

	typedef struct {
		cst_pkg::req_t r;
		bit            typed;
		cst_pkg::rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	cst_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	cst_pkg::rsp_t rsp;

	// model state of the semaphore bank
	logic [cst_pkg::VALUE_W-1:0] sem_val [SEM_COUNT];
	logic [cst_pkg::REF_W-1:0]   ref_cnt [SEM_COUNT];

	cst_pkg::rsp_t pending_rsps [$];
	plan_row_t     plan [$];
	int            mismatches = 0;
	int            sent = 0;
	int            cycles = 0;
	bit            req_steady = 1'b0;
	bit            rsp_steady = 1'b0;
	int            rsp_hold = 0;
	cst_pkg::rsp_t rsp_want;

	counting_semaphore_table_core #(
		.SEM_COUNT(SEM_COUNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// apply one request to the model bank and return its response
	function automatic cst_pkg::rsp_t apply_request(input cst_pkg::req_t r);
		cst_pkg::rsp_t               res;
		logic [cst_pkg::REF_W-1:0]   rc;
		logic [cst_pkg::VALUE_W-1:0] v;
		int unsigned                 i;
		res.status = cst_pkg::ST_ERR;
		res.open_count = '0;
		i = r.sem_index;
		if (i < SEM_COUNT) begin
			rc = ref_cnt[i];
			v = sem_val[i];
			case (r.operation)
				cst_pkg::OP_CREATE: begin
					if (rc == '0) begin
						sem_val[i] = r.init_value;
						ref_cnt[i] = 8'd1;
						res.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_OPEN: begin
					if (rc != '0 && rc != cst_pkg::REF_MAX) begin
						ref_cnt[i] = rc + 8'd1;
						res.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_OPEN_OR_CREATE: begin
					if (rc == '0) begin
						sem_val[i] = r.init_value;
						ref_cnt[i] = 8'd1;
						res.status = cst_pkg::ST_OK;
					end else if (rc != cst_pkg::REF_MAX) begin
						ref_cnt[i] = rc + 8'd1;
						res.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_CLOSE: begin
					res.status = cst_pkg::ST_OK;
					if (rc != '0) begin
						ref_cnt[i] = rc - 8'd1;
						res.open_count = rc - 8'd1;
					end
				end
				cst_pkg::OP_UP: begin
					if (rc != '0 && v != cst_pkg::VALUE_MAX) begin
						sem_val[i] = v + 16'd1;
						res.status = cst_pkg::ST_OK;
					end
				end
				cst_pkg::OP_DOWN: begin
					if (rc != '0) begin
						if (v == '0) begin
							res.status = cst_pkg::ST_BLOCK;
						end else begin
							sem_val[i] = v - 16'd1;
							res.status = cst_pkg::ST_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
		return res;
	endfunction

	function automatic logic [cst_pkg::VALUE_W-1:0] pick_init();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(16'hFFFC, 16'hFFFF));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic cst_pkg::req_t make_req(input logic [cst_pkg::OP_W-1:0] op,
			input int idx, input logic [cst_pkg::VALUE_W-1:0] init);
		cst_pkg::req_t r;
		r.operation = op;
		r.sem_index = idx[cst_pkg::IDX_W-1:0];
		r.init_value = init;
		return r;
	endfunction

	task automatic add_row(input logic [cst_pkg::OP_W-1:0] op, input int idx,
			input logic [cst_pkg::VALUE_W-1:0] init, input bit typed,
			input logic [cst_pkg::STATUS_W-1:0] st, input logic [cst_pkg::REF_W-1:0] cnt);
		plan_row_t row;
		row.r = make_req(op, idx, init);
		row.typed = typed;
		row.want.status = st;
		row.want.open_count = cnt;
		plan.push_back(row);
	endtask

	// present one request after a random gap and hold it until accepted
	task automatic send_request(input cst_pkg::req_t r, input bit typed,
			input cst_pkg::rsp_t want);
		int            gap;
		cst_pkg::rsp_t pred;
		if ($urandom_range(0, 39) == 0)
			req_steady = !req_steady;
		gap = req_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		pred = apply_request(r);
		pending_rsps.push_back(typed ? want : pred);
		sent++;
	endtask

	task automatic send_checked(input cst_pkg::req_t r);
		send_request(r, 1'b0, '0);
	endtask

	// hold off the sender until every response is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// response side: random stalls, in-order compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsps.size() == 0) begin
					$display("%0t: response with no request pending: status %0d count %0d",
						$time, rsp.status, rsp.open_count);
					mismatches++;
				end else begin
					rsp_want = pending_rsps.pop_front();
					if (rsp.status !== rsp_want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, rsp_want.status, rsp.status);
						mismatches++;
					end
					if (rsp.open_count !== rsp_want.open_count) begin
						$display("%0t: open_count expected %0d got %0d",
							$time, rsp_want.open_count, rsp.open_count);
						mismatches++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					rsp_steady = !rsp_steady;
				rsp_hold = rsp_steady ? 0 : $urandom_range(0, 7);
			end
			if (rsp_hold > 0) begin
				rsp_ready <= 1'b0;
				rsp_hold--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : main
		int          k;
		int          n;
		int          idx;
		bit          paused_mid;
		logic [cst_pkg::OP_W-1:0] op;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		paused_mid = 1'b0;
		for (k = 0; k < SEM_COUNT; k++) begin
			sem_val[k] = '0;
			ref_cnt[k] = '0;
		end

		// directed table: unopened entries, bad index, bad codes, limits
		add_row(cst_pkg::OP_UP, 0, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_DOWN, SEM_COUNT - 1, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_CLOSE, 3, 16'h0000, 1'b1, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_OPEN, 1, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_CREATE, 255, 16'hFFFF, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_CREATE, SEM_COUNT, 16'h0001, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(OP_RSVD_6, 0, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(OP_RSVD_7, 0, 16'hFFFF, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_CREATE, 0, 16'h0000, 1'b1, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_DOWN, 0, 16'h0000, 1'b1, cst_pkg::ST_BLOCK, 8'd0);
		add_row(cst_pkg::OP_CREATE, 0, 16'h1234, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_UP, 0, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_DOWN, 0, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(OP_RSVD_6, 0, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_OPEN_OR_CREATE, SEM_COUNT - 1, 16'hFFFF, 1'b1,
			cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_UP, SEM_COUNT - 1, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);
		add_row(cst_pkg::OP_DOWN, SEM_COUNT - 1, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_UP, SEM_COUNT - 1, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_OPEN, SEM_COUNT - 1, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_OPEN_OR_CREATE, SEM_COUNT - 1, 16'h0000, 1'b0,
			cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_CLOSE, SEM_COUNT - 1, 16'h0000, 1'b1, cst_pkg::ST_OK, 8'd2);
		add_row(cst_pkg::OP_CLOSE, SEM_COUNT - 1, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_CLOSE, SEM_COUNT - 1, 16'h0000, 1'b0, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_CLOSE, SEM_COUNT - 1, 16'h0000, 1'b1, cst_pkg::ST_OK, 8'd0);
		add_row(cst_pkg::OP_UP, SEM_COUNT - 1, 16'h0000, 1'b1, cst_pkg::ST_ERR, 8'd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[j])
			send_request(plan[j].r, plan[j].typed, plan[j].want);
		wait_drained();

		// fill one entry's reference count to the top, then one open past it
		for (k = 0; k < 256; k++)
			send_checked(make_req(cst_pkg::OP_OPEN_OR_CREATE, FILL_INDEX, pick_init()));
		send_request(make_req(cst_pkg::OP_OPEN, FILL_INDEX, 16'h0000), 1'b1,
			'{cst_pkg::ST_ERR, 8'd0});
		wait_drained();

		// random part: open, up/down traffic, close, with noise in between
		while (sent < ITEM_TARGET) begin
			if (!paused_mid && sent >= PAUSE_AT) begin
				wait_drained();
				paused_mid = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				send_checked(make_req(cst_pkg::OP_W'($urandom_range(0, 7)),
					$urandom_range(0, 255), 16'($urandom_range(0, 16'hFFFF))));
			end else begin
				idx = $urandom_range(0, SEM_COUNT - 1);
				op = $urandom_range(0, 1) ? cst_pkg::OP_OPEN_OR_CREATE : cst_pkg::OP_CREATE;
				send_checked(make_req(op, idx, pick_init()));
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 9))
						0: op = cst_pkg::OP_OPEN;
						1, 2, 3, 4: op = cst_pkg::OP_UP;
						default: op = cst_pkg::OP_DOWN;
					endcase
					send_checked(make_req(op, idx, 16'($urandom_range(0, 16'hFFFF))));
				end
				if ($urandom_range(0, 9) < 7)
					send_checked(make_req(cst_pkg::OP_CLOSE, idx,
						16'($urandom_range(0, 16'hFFFF))));
			end
		end

		// wait for the tail, then idle for anything stray
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cst_pkg.sv
hw/rtl/cst_ram.sv
hw/rtl/counting_semaphore_table_core.sv
tb/sv/tb.sv
